/* sv/rscg_pkg.sv */
// Shared types, widths and constants for the rotary sin/cos table generator.
package rscg_pkg;

    localparam int POS_W     = 20;
    localparam int CNT_W     = 7;
    localparam int IDX_W     = 6;
    localparam int SLOT_W    = 7;
    localparam int WORD_W    = 32;
    localparam int SP_W      = 52;
    localparam int ANG_W     = 62;
    localparam int CORD_W    = 34;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAIR_COUNT    = 3'd0,
        CFG_FREQ_RATIO    = 3'd1,
        CFG_POS_GAIN      = 3'd2,
        CFG_MAG_GAIN      = 3'd3,
        CFG_LAYOUT_HALVES = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_SCALE,
        SEQ_RUN
    } seq_state_t;

    typedef struct packed {
        logic [IDX_W-1:0]  pair_index;
        logic [SLOT_W-1:0] first_slot;
        logic [SLOT_W-1:0] second_slot;
        logic              last;
    } pair_tag_t;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    localparam logic [WORD_W-1:0] ONE_Q32        = 32'hFFFF_FFFF;
    localparam logic [63:0]       POWER_ROUND    = 64'h0000_0000_8000_0000;
    localparam logic [63:0]       INV_TWO_PI_Q64 = 64'h28BE_60DB_9391_054A;
    localparam logic [30:0]       HALF_PI_Q30    = 31'h6487_ED51;
    localparam logic [WORD_W-1:0] QUARTER_TURN   = 32'h4000_0000;
    localparam logic [30:0]       EIGHTH_TURN    = 31'h2000_0000;
    localparam logic [CORD_W-1:0] CORDIC_GAIN    = 34'h0_26DD_3B6A;
    localparam logic [63:0]       SCALE_ROUND    = 64'h0000_0000_4000_0000;

    localparam logic [WORD_W-1:0] ATAN_Q30 [32] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
        32'h00000001, 32'h00000000
    };

endpackage

/* sv/rscg_sequencer.sv */
// Per-position sequencer: scales the position and issues one pair per cycle while adv is high.
module rscg_sequencer import rscg_pkg::*; #(
    parameter int MAX_PAIRS = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [POS_W-1:0]  s_position,
    input  logic [CNT_W-1:0]  pair_count,
    input  logic [WORD_W-1:0] freq_ratio,
    input  logic [WORD_W-1:0] pos_gain,
    input  logic              layout_halves,
    input  logic              adv,
    output logic              issue_valid,
    output pair_tag_t         issue_tag,
    output logic [SP_W-1:0]   issue_sp,
    output logic [WORD_W-1:0] issue_power
);

    localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_PAIRS);

    seq_state_t        state_reg, state_next;
    logic [POS_W-1:0]  pos_reg;
    logic [CNT_W-1:0]  n_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [WORD_W-1:0] power_reg;
    logic [SP_W-1:0]   sp_reg;
    logic [CNT_W-1:0]  n_lim;
    logic              is_last;
    logic [63:0]       power_prod;

    assign n_lim      = (pair_count > MAX_N) ? MAX_N : pair_count;
    assign is_last    = ((cnt_reg + CNT_W'(1)) == n_reg);
    assign power_prod = 64'(power_reg) * 64'(freq_ratio) + POWER_ROUND;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            SEQ_IDLE:  if (s_valid && (n_lim != '0)) state_next = SEQ_SCALE;
            SEQ_SCALE: state_next = SEQ_RUN;
            SEQ_RUN:   if (adv && is_last) state_next = SEQ_IDLE;
            default:   state_next = SEQ_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        s_ready     = (state_reg == SEQ_IDLE);
        issue_valid = (state_reg == SEQ_RUN);
        issue_sp    = sp_reg;
        issue_power = power_reg;
        issue_tag.pair_index = cnt_reg[IDX_W-1:0];
        issue_tag.last       = is_last;
        if (layout_halves) begin
            issue_tag.first_slot  = cnt_reg;
            issue_tag.second_slot = cnt_reg + n_reg;
        end else begin
            issue_tag.first_slot  = {cnt_reg[IDX_W-1:0], 1'b0};
            issue_tag.second_slot = {cnt_reg[IDX_W-1:0], 1'b1};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= SEQ_IDLE;
        else          state_reg <= state_next;
    end

    // Capture the position, scale it, then step the running power
    always_ff @(posedge aclk) begin
        if (state_reg == SEQ_IDLE && s_valid) begin
            pos_reg   <= s_position;
            n_reg     <= n_lim;
            cnt_reg   <= '0;
            power_reg <= ONE_Q32;
        end
        if (state_reg == SEQ_SCALE) begin
            if (layout_halves) sp_reg <= SP_W'(pos_reg) * SP_W'(pos_gain);
            else               sp_reg <= SP_W'({pos_reg, 24'b0});
        end
        if (state_reg == SEQ_RUN && adv) begin
            cnt_reg   <= cnt_reg + CNT_W'(1);
            power_reg <= power_prod[63:32];
        end
    end

endmodule

/* sv/rscg_phase.sv */
// Angle product, turn reduction and residual-to-radians pipeline.
module rscg_phase import rscg_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     adv,
    input  logic                     in_valid,
    input  pair_tag_t                in_tag,
    input  logic [SP_W-1:0]          in_sp,
    input  logic [WORD_W-1:0]        in_power,
    output logic                     out_valid,
    output pair_tag_t                out_tag,
    output logic [1:0]               out_quad,
    output logic signed [CORD_W-1:0] out_z
);

    logic [5:0]      v_reg;
    pair_tag_t       tag_reg [6];

    logic [51:0]     phi_reg;
    logic [63:0]     plo_reg;
    logic [ANG_W-1:0] ang_reg;
    logic [63:0]     p00_reg, p01_reg, p10_reg, p11_reg;
    logic [WORD_W-1:0] phase_reg;
    logic [60:0]     zprod_reg;
    logic            zneg_reg;
    logic [1:0]      quad_reg, quad2_reg;
    logic signed [CORD_W-1:0] z_reg;

    logic [63:0]     ang_sum;
    logic [33:0]     mid;
    logic [63:0]     hi;
    logic [WORD_W-1:0] t_word;
    logic signed [31:0] r_res;
    logic [29:0]     r_mag;
    logic [WORD_W-1:0] zm;

    assign ang_sum = ({12'b0, phi_reg} << 8) + {24'b0, plo_reg[63:24]};
    assign mid = 34'(p00_reg[63:32]) + 34'(p01_reg[31:0]) + 34'(p10_reg[31:0]);
    assign hi  = p11_reg + 64'(p01_reg[63:32]) + 64'(p10_reg[63:32]) + 64'(mid[33:32]);
    assign t_word = phase_reg + QUARTER_TURN;
    assign r_res  = signed'({2'b0, t_word[29:0]}) - signed'({1'b0, EIGHTH_TURN});
    assign r_mag  = r_res[31] ? 30'(-r_res) : r_res[29:0];
    assign zm     = {1'b0, zprod_reg[60:30]};

    // Advance valid bits with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) v_reg <= '0;
        else if (adv) v_reg <= {v_reg[4:0], in_valid};
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            tag_reg[0] <= in_tag;
            for (int i = 1; i < 6; i++) tag_reg[i] <= tag_reg[i-1];
            // angle partial products
            phi_reg <= 52'(in_sp[SP_W-1:32]) * 52'(in_power);
            plo_reg <= 64'(in_sp[31:0]) * 64'(in_power);
            // angle in Q28.32
            ang_reg <= ang_sum[ANG_W-1:0];
            // products with the inverse of one turn
            p00_reg <= 64'(ang_reg[31:0]) * 64'(INV_TWO_PI_Q64[31:0]);
            p01_reg <= 64'(ang_reg[31:0]) * 64'(INV_TWO_PI_Q64[63:32]);
            p10_reg <= 64'(ang_reg[ANG_W-1:32]) * 64'(INV_TWO_PI_Q64[31:0]);
            p11_reg <= 64'(ang_reg[ANG_W-1:32]) * 64'(INV_TWO_PI_Q64[63:32]);
            // turn phase in Q0.32
            phase_reg <= hi[31:0];
            // split quadrant and residual, scale residual to radians
            quad_reg  <= t_word[31:30];
            zneg_reg  <= r_res[31];
            zprod_reg <= 61'(r_mag) * 61'(HALF_PI_Q30);
            // restore residual sign
            quad2_reg <= quad_reg;
            z_reg     <= zneg_reg ? -signed'(CORD_W'(zm)) : signed'(CORD_W'(zm));
        end
    end

    assign out_valid = v_reg[5];
    assign out_tag   = tag_reg[5];
    assign out_quad  = quad2_reg;
    assign out_z     = z_reg;

endmodule

/* sv/rscg_cordic.sv */
// Rotation-mode CORDIC, one register stage per iteration.
module rscg_cordic import rscg_pkg::*; #(
    parameter int CORDIC_STAGES = 30
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     adv,
    input  logic                     in_valid,
    input  pair_tag_t                in_tag,
    input  logic [1:0]               in_quad,
    input  logic signed [CORD_W-1:0] in_z,
    output logic                     out_valid,
    output pair_tag_t                out_tag,
    output logic [1:0]               out_quad,
    output logic signed [CORD_W-1:0] out_x,
    output logic signed [CORD_W-1:0] out_y
);

    logic                     v_reg    [CORDIC_STAGES];
    pair_tag_t                tag_reg  [CORDIC_STAGES];
    logic [1:0]               quad_reg [CORDIC_STAGES];
    logic signed [CORD_W-1:0] x_reg    [CORDIC_STAGES];
    logic signed [CORD_W-1:0] y_reg    [CORDIC_STAGES];
    logic signed [CORD_W-1:0] z_reg    [CORDIC_STAGES];

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
        localparam logic signed [CORD_W-1:0] ATAN_K = CORD_W'(ATAN_Q30[k]);
        logic                     v_in;
        pair_tag_t                tag_in;
        logic [1:0]               quad_in;
        logic signed [CORD_W-1:0] x_in, y_in, z_in;

        if (k == 0) begin : g_first
            assign v_in    = in_valid;
            assign tag_in  = in_tag;
            assign quad_in = in_quad;
            assign x_in    = signed'(CORDIC_GAIN);
            assign y_in    = '0;
            assign z_in    = in_z;
        end else begin : g_next
            assign v_in    = v_reg[k-1];
            assign tag_in  = tag_reg[k-1];
            assign quad_in = quad_reg[k-1];
            assign x_in    = x_reg[k-1];
            assign y_in    = y_reg[k-1];
            assign z_in    = z_reg[k-1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn)  v_reg[k] <= 1'b0;
            else if (adv)  v_reg[k] <= v_in;
        end

        // Rotate toward zero residual angle
        always_ff @(posedge aclk) begin
            if (adv) begin
                tag_reg[k]  <= tag_in;
                quad_reg[k] <= quad_in;
                if (!z_in[CORD_W-1]) begin
                    x_reg[k] <= x_in - (y_in >>> k);
                    y_reg[k] <= y_in + (x_in >>> k);
                    z_reg[k] <= z_in - ATAN_K;
                end else begin
                    x_reg[k] <= x_in + (y_in >>> k);
                    y_reg[k] <= y_in - (x_in >>> k);
                    z_reg[k] <= z_in + ATAN_K;
                end
            end
        end
    end

    assign out_valid = v_reg[CORDIC_STAGES-1];
    assign out_tag   = tag_reg[CORDIC_STAGES-1];
    assign out_quad  = quad_reg[CORDIC_STAGES-1];
    assign out_x     = x_reg[CORDIC_STAGES-1];
    assign out_y     = y_reg[CORDIC_STAGES-1];

endmodule

/* sv/rscg_scale.sv */
// Quadrant fix-up and magnitude scaling by the attention factor.
module rscg_scale import rscg_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     adv,
    input  logic                     in_valid,
    input  pair_tag_t                in_tag,
    input  logic [1:0]               in_quad,
    input  logic signed [CORD_W-1:0] in_x,
    input  logic signed [CORD_W-1:0] in_y,
    input  logic [WORD_W-1:0]        mag_gain,
    output logic                     out_valid,
    output pair_tag_t                out_tag,
    output logic                     out_sin_neg,
    output logic                     out_cos_neg,
    output logic [63:0]              out_sin_prod,
    output logic [63:0]              out_cos_prod
);

    logic [1:0]        v_reg;
    pair_tag_t         tag_reg [2];
    logic              sneg_reg [2];
    logic              cneg_reg [2];
    logic [WORD_W-1:0] smag_reg, cmag_reg;
    logic [63:0]       sprod_reg, cprod_reg;
    logic signed [CORD_W-1:0] s_sel, c_sel, s_abs, c_abs;

    // Rotate back by the quadrant
    always_comb begin
        case (in_quad)
            QUAD_0:  begin c_sel = in_x;  s_sel = in_y;  end
            QUAD_1:  begin c_sel = -in_y; s_sel = in_x;  end
            QUAD_2:  begin c_sel = -in_x; s_sel = -in_y; end
            default: begin c_sel = in_y;  s_sel = -in_x; end
        endcase
        s_abs = s_sel[CORD_W-1] ? -s_sel : s_sel;
        c_abs = c_sel[CORD_W-1] ? -c_sel : c_sel;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) v_reg <= '0;
        else if (adv) v_reg <= {v_reg[0], in_valid};
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            tag_reg[0]  <= in_tag;
            sneg_reg[0] <= s_sel[CORD_W-1];
            cneg_reg[0] <= c_sel[CORD_W-1];
            smag_reg    <= s_abs[WORD_W-1:0];
            cmag_reg    <= c_abs[WORD_W-1:0];
            // scale magnitudes, add rounding half
            tag_reg[1]  <= tag_reg[0];
            sneg_reg[1] <= sneg_reg[0];
            cneg_reg[1] <= cneg_reg[0];
            sprod_reg   <= 64'(smag_reg) * 64'(mag_gain) + SCALE_ROUND;
            cprod_reg   <= 64'(cmag_reg) * 64'(mag_gain) + SCALE_ROUND;
        end
    end

    assign out_valid    = v_reg[1];
    assign out_tag      = tag_reg[1];
    assign out_sin_neg  = sneg_reg[1];
    assign out_cos_neg  = cneg_reg[1];
    assign out_sin_prod = sprod_reg;
    assign out_cos_prod = cprod_reg;

endmodule

/* sv/rope_sin_cos_table_generator_unit.sv */
// Throughput: one pair per cycle while the output word is empty or taken. A new position
// is taken only in the idle state, after the scaling state and the issue of every pair
// of the last position. A zero count leaves the sequencer idle and issues no pair.
// Reset: aresetn synchronous low; configuration registers return to their defaults and all
// pipeline valid bits clear.
module rope_sin_cos_table_generator_unit import rscg_pkg::*; #(
    parameter int MAX_PAIRS     = 64,
    parameter int CORDIC_STAGES = 30
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [POS_W-1:0]        s_position,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [IDX_W-1:0]        m_pair_index,
    output logic [SLOT_W-1:0]       m_first_slot,
    output logic [SLOT_W-1:0]       m_second_slot,
    output logic signed [WORD_W-1:0] m_sin_value,
    output logic signed [WORD_W-1:0] m_cos_value,
    output logic                    m_last,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [WORD_W-1:0]       cfg_data
);

    logic [CNT_W-1:0]  pair_count_reg;
    logic [WORD_W-1:0] freq_ratio_reg, pos_gain_reg, mag_gain_reg;
    logic              layout_halves_reg;

    logic              adv;
    logic              iss_valid;
    pair_tag_t         iss_tag;
    logic [SP_W-1:0]   iss_sp;
    logic [WORD_W-1:0] iss_power;
    logic              ph_valid;
    pair_tag_t         ph_tag;
    logic [1:0]        ph_quad;
    logic signed [CORD_W-1:0] ph_z;
    logic              cd_valid;
    pair_tag_t         cd_tag;
    logic [1:0]        cd_quad;
    logic signed [CORD_W-1:0] cd_x, cd_y;
    logic              sc_valid, sc_sneg, sc_cneg;
    pair_tag_t         sc_tag;
    logic [63:0]       sc_sprod, sc_cprod;

    function automatic logic [WORD_W-1:0] saturate(input logic neg, input logic [63:0] prod);
        logic [32:0] q;
        logic [33:0] nq;
        begin
            q  = prod[63:31];
            nq = -34'(q);
            if (neg) saturate = (q > 33'h0_8000_0000) ? 32'h8000_0000 : nq[31:0];
            else     saturate = (q > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
        end
    endfunction

    assign cfg_ready = 1'b1;

    // Register writes; unknown indexes drop
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pair_count_reg    <= CNT_W'(64);
            freq_ratio_reg    <= 32'd3719550786;
            pos_gain_reg      <= 32'd16777216;
            mag_gain_reg      <= 32'd1073741824;
            layout_halves_reg <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                CFG_PAIR_COUNT:    pair_count_reg    <= cfg_data[CNT_W-1:0];
                CFG_FREQ_RATIO:    freq_ratio_reg    <= cfg_data;
                CFG_POS_GAIN:      pos_gain_reg      <= cfg_data;
                CFG_MAG_GAIN:      mag_gain_reg      <= cfg_data;
                CFG_LAYOUT_HALVES: layout_halves_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Whole pipeline moves when the output word is empty or taken
    assign adv = !m_valid || m_ready;

    rscg_sequencer #(.MAX_PAIRS(MAX_PAIRS)) u_seq (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_position(s_position),
        .pair_count(pair_count_reg), .freq_ratio(freq_ratio_reg),
        .pos_gain(pos_gain_reg), .layout_halves(layout_halves_reg),
        .adv(adv),
        .issue_valid(iss_valid), .issue_tag(iss_tag),
        .issue_sp(iss_sp), .issue_power(iss_power)
    );

    rscg_phase u_phase (
        .aclk(aclk), .aresetn(aresetn), .adv(adv),
        .in_valid(iss_valid), .in_tag(iss_tag), .in_sp(iss_sp), .in_power(iss_power),
        .out_valid(ph_valid), .out_tag(ph_tag), .out_quad(ph_quad), .out_z(ph_z)
    );

    rscg_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
        .aclk(aclk), .aresetn(aresetn), .adv(adv),
        .in_valid(ph_valid), .in_tag(ph_tag), .in_quad(ph_quad), .in_z(ph_z),
        .out_valid(cd_valid), .out_tag(cd_tag), .out_quad(cd_quad),
        .out_x(cd_x), .out_y(cd_y)
    );

    rscg_scale u_scale (
        .aclk(aclk), .aresetn(aresetn), .adv(adv),
        .in_valid(cd_valid), .in_tag(cd_tag), .in_quad(cd_quad),
        .in_x(cd_x), .in_y(cd_y), .mag_gain(mag_gain_reg),
        .out_valid(sc_valid), .out_tag(sc_tag),
        .out_sin_neg(sc_sneg), .out_cos_neg(sc_cneg),
        .out_sin_prod(sc_sprod), .out_cos_prod(sc_cprod)
    );

    // Output word register
    always_ff @(posedge aclk) begin
        if (!aresetn)  m_valid <= 1'b0;
        else if (adv)  m_valid <= sc_valid;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_pair_index  <= sc_tag.pair_index;
            m_first_slot  <= sc_tag.first_slot;
            m_second_slot <= sc_tag.second_slot;
            m_last        <= sc_tag.last;
            m_sin_value   <= saturate(sc_sneg, sc_sprod);
            m_cos_value   <= saturate(sc_cneg, sc_cprod);
        end
    end

    // Interleaved slots are the adjacent pair 2i, 2i+1
    a_interleaved_slots: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !layout_halves_reg) |->
            (m_first_slot == {m_pair_index, 1'b0}) && (m_second_slot == {m_pair_index, 1'b1}))
        else $error("interleaved slot mismatch");

    // Halves layout: first slot equals the pair index
    a_halves_slots: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && layout_halves_reg) |-> (m_first_slot == SLOT_W'(m_pair_index)))
        else $error("halves slot mismatch");

    // A zero pair count leaves the sequencer ready
    a_zero_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (pair_count_reg == '0)) |=> s_ready)
        else $error("sequencer left idle on zero pair count");

endmodule

/* bench/rope_table_checker.sv */
// Checker for the rotary sin/cos table generator: predicts each pair and compares.
module rope_table_checker import rscg_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic [POS_W-1:0]         s_position,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic [IDX_W-1:0]         m_pair_index,
    input  logic [SLOT_W-1:0]        m_first_slot,
    input  logic [SLOT_W-1:0]        m_second_slot,
    input  logic signed [WORD_W-1:0] m_sin_value,
    input  logic signed [WORD_W-1:0] m_cos_value,
    input  logic                     m_last,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [WORD_W-1:0]        cfg_data,
    output int                       fail_count,
    output int                       pending_pairs,
    output int                       pairs_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [IDX_W-1:0]  pair_index;
        logic [SLOT_W-1:0] first_slot;
        logic [SLOT_W-1:0] second_slot;
        logic [31:0]       sin_value;
        logic [31:0]       cos_value;
        logic              last;
    } rope_pair_t;

    rope_pair_t  pair_queue[$];
    logic [6:0]  m_pairs;
    logic [31:0] m_theta, m_freq, m_attn;
    logic        m_halves;

    // Arithmetic shift right of a signed value.
    function automatic longint asr(longint v, int k);
        return v >>> k;
    endfunction

    // Scale a Q2.30 value by the attenuation, round away from zero, saturate.
    function automatic logic [31:0] attn_scale(longint v);
        logic [63:0] mag, q;
        mag = v < 0 ? -v : v;
        q = (mag * {32'd0, m_attn} + 64'h4000_0000) >> 31;
        if (v < 0)
            return q > 64'h8000_0000 ? 32'h8000_0000 : 32'(-q);
        return q > 64'h7FFF_FFFF ? 32'h7FFF_FFFF : q[31:0];
    endfunction

    // Reduce a turn phase to a quadrant, then rotate with CORDIC.
    task automatic phase_sin_cos(input logic [31:0] phase, output longint s, output longint c);
        logic [31:0]  t;
        logic [1:0]   quad;
        longint       r, z, x, y, dx, dy;
        logic [63:0]  rm;
        t = phase + 32'h4000_0000;
        quad = t[31:30];
        r = longint'({32'd0, 2'b00, t[29:0]}) - 64'sh2000_0000;
        rm = r < 0 ? -r : r;
        z = longint'((rm * 64'h6487_ED51) >> 30);
        if (r < 0) z = -z;
        x = 64'sh26DD_3B6A;
        y = 0;
        for (int k = 0; k < 30; k++) begin
            dx = asr(y, k);
            dy = asr(x, k);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(ATAN_Q30[k]);
            end else begin
                x += dx; y -= dy; z += longint'(ATAN_Q30[k]);
            end
        end
        case (quad)
            2'd0: begin c = x; s = y; end
            2'd1: begin c = -y; s = x; end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endtask

    // Queue every expected pair for one position.
    task automatic predict_position(input logic [POS_W-1:0] pos);
        int          n;
        logic [63:0] sp, p, ang, a0, a1, p00, p01, p10, p11, mid, hi;
        longint      s, c;
        rope_pair_t  e;
        n = m_pairs > 64 ? 64 : m_pairs;
        sp = m_halves ? {44'd0, pos} * {32'd0, m_freq} : {44'd0, pos} << 24;
        p = 64'hFFFF_FFFF;
        for (int i = 0; i < n; i++) begin
            ang = (((sp >> 32) * p) << 8) + (((sp & 64'hFFFF_FFFF) * p) >> 24);
            a0 = ang & 64'hFFFF_FFFF; a1 = ang >> 32;
            p00 = a0 * 64'h9391_054A; p01 = a0 * 64'h28BE_60DB;
            p10 = a1 * 64'h9391_054A; p11 = a1 * 64'h28BE_60DB;
            mid = (p00 >> 32) + (p01 & 64'hFFFF_FFFF) + (p10 & 64'hFFFF_FFFF);
            hi = p11 + (p01 >> 32) + (p10 >> 32) + (mid >> 32);
            phase_sin_cos(hi[31:0], s, c);
            e.pair_index = i[5:0];
            e.first_slot = m_halves ? i[6:0] : 7'(2 * i);
            e.second_slot = m_halves ? 7'(i + n) : 7'(2 * i + 1);
            e.sin_value = attn_scale(s);
            e.cos_value = attn_scale(c);
            e.last = (i + 1 == n);
            pair_queue.push_back(e);
            p = (p * {32'd0, m_theta} + 64'h8000_0000) >> 32;
        end
    endtask

    assign pending_pairs = pair_queue.size();

    // Track registers, predict on each accepted position, compare each pair.
    always @(posedge aclk) begin
        rope_pair_t e;
        if (!aresetn) begin
            m_pairs <= 7'd64; m_theta <= 32'd3719550786; m_freq <= 32'd16777216;
            m_attn <= 32'd1073741824; m_halves <= 1'b0;
            pair_queue.delete();
            fail_count <= 0;
            pairs_seen <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_PAIR_COUNT:    m_pairs <= cfg_data[6:0];
                    CFG_FREQ_RATIO:    m_theta <= cfg_data;
                    CFG_POS_GAIN:      m_freq <= cfg_data;
                    CFG_MAG_GAIN:      m_attn <= cfg_data;
                    CFG_LAYOUT_HALVES: m_halves <= cfg_data[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) predict_position(s_position);
            if (m_valid && m_ready) begin
                pairs_seen <= pairs_seen + 1;
                if (pair_queue.size() == 0) begin
                    $display("%t: unexpected pair idx=%0d", $realtime, m_pair_index);
                    fail_count <= fail_count + 1;
                end else begin
                    e = pair_queue.pop_front();
                    if (e.pair_index !== m_pair_index || e.first_slot !== m_first_slot ||
                        e.second_slot !== m_second_slot || e.sin_value !== m_sin_value ||
                        e.cos_value !== m_cos_value || e.last !== m_last) begin
                        $display("%t: expected idx=%0d slots=%0d/%0d sin=%h cos=%h last=%b",
                                 $realtime, e.pair_index, e.first_slot, e.second_slot,
                                 e.sin_value, e.cos_value, e.last);
                        $display("%t: actual   idx=%0d slots=%0d/%0d sin=%h cos=%h last=%b",
                                 $realtime, m_pair_index, m_first_slot, m_second_slot,
                                 m_sin_value, m_cos_value, m_last);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

/* bench/tb.sv */
// Top of the bench: stimulus, idling, register phases and the verdict.
module tb;
    import rscg_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG = 20000;

    logic                     aclk, aresetn;
    logic                     s_valid, s_ready, m_valid, m_ready;
    logic [POS_W-1:0]         s_position;
    logic [IDX_W-1:0]         m_pair_index;
    logic [SLOT_W-1:0]        m_first_slot, m_second_slot;
    logic signed [WORD_W-1:0] m_sin_value, m_cos_value;
    logic                     m_last;
    logic                     cfg_valid, cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [WORD_W-1:0]        cfg_data;
    int                       fail_count, pending_pairs, pairs_seen;
    int                       sender_idle, receiver_idle, positions_sent, quiet_cycles;

    rope_sin_cos_table_generator_unit dut (.*);
    rope_table_checker checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Stall the result side at random.
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(99) >= receiver_idle);
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready) || !aresetn)
            quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Write one register, then drop valid and leave the channel idle.
    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Drop the input, wait for all pairs, then let the pipeline drain.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_pairs != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    // Hold valid across back-to-back words; drop it only while idling.
    task automatic send_position(input logic [POS_W-1:0] pos);
        while ($urandom_range(99) < sender_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_position <= pos;
        do @(posedge aclk); while (!s_ready);
        positions_sent++;
    endtask

    task automatic load_setting(input logic [6:0] pc, input logic [31:0] th,
                                input logic [31:0] fr, input logic [31:0] at, input logic h);
        drain();
        write_reg(CFG_PAIR_COUNT, {25'd0, pc});
        write_reg(CFG_FREQ_RATIO, th);
        write_reg(CFG_POS_GAIN, fr);
        write_reg(CFG_MAG_GAIN, at);
        write_reg(CFG_LAYOUT_HALVES, {31'd0, h});
    endtask

    function automatic logic [POS_W-1:0] rand_position();
        case ($urandom_range(3))
            0: return POS_W'($urandom_range(15));
            1: return 20'hFFFFF - POS_W'($urandom_range(15));
            default: return POS_W'($urandom);
        endcase
    endfunction

    initial begin
        aresetn = 1'b0; s_valid = 1'b0; s_position = '0;
        cfg_valid = 1'b0; cfg_index = CFG_PAIR_COUNT; cfg_data = '0;
        sender_idle = 0; receiver_idle = 0; positions_sent = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: default registers, then extremes and special settings.
        send_position(20'd0);
        send_position(20'hFFFFF);
        send_position(20'd1);
        send_position(20'h55555);
        load_setting(7'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_position(20'd7);
        send_position(20'hAAAAA);
        load_setting(7'd127, 32'd0, 32'd0, 32'd0, 1'b1);
        send_position(20'hFFFFF);
        send_position(20'd3);
        load_setting(7'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_position(20'hFFFFF);
        send_position(20'd0);
        load_setting(7'd65, 32'h8000_0000, 32'h0100_0000, 32'h4000_0000, 1'b1);
        send_position(20'hFFFFF);
        send_position(20'd12345);
        drain();
        write_reg(cfg_reg_t'(3'd7), 32'hFFFF_FFFF);
        write_reg(cfg_reg_t'(3'd5), 32'h0000_0000);
        send_position(20'd100);

        // Random phases: receiver idles more than sender, then sender more than receiver, then neither.
        for (int ph = 0; ph < 3; ph++) begin
            sender_idle = ph == 0 ? 29 : ph == 1 ? 57 : 0;
            receiver_idle = ph == 0 ? 57 : ph == 1 ? 29 : 0;
            for (int b = 0; b < 6; b++) begin
                load_setting($urandom_range(3) == 0 ? 7'($urandom) : 7'($urandom_range(1, 12)),
                             $urandom, $urandom, $urandom, 1'($urandom));
                for (int j = 0; j < 23; j++) begin
                    send_position(rand_position());
                    if (j == 11 && b == 2) drain();
                end
            end
        end

        drain();
        $display("Covered %0d positions and %0d pairs over random register settings.",
                 positions_sent, pairs_seen);
        if (fail_count == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

/* rope_sin_cos_table_generator_unit.f */
sv/rscg_pkg.sv
sv/rscg_sequencer.sv
sv/rscg_phase.sv
sv/rscg_cordic.sv
sv/rscg_scale.sv
sv/rope_sin_cos_table_generator_unit.sv
bench/rope_table_checker.sv
bench/tb.sv
